// ===== rtl/sfp_pkg.sv =====
package sfp_pkg;

   localparam int BufferBytes = 32;

   localparam logic [7:0]  SyncHigh      = 8'h42;
   localparam logic [7:0]  SyncLow       = 8'h4D;
   localparam logic [15:0] SyncWord      = 16'h424D;
   localparam logic [15:0] SyncSum       = 16'h008F;
   localparam logic [15:0] StdLength     = 16'd28;
   localparam logic [10:0] ElapsedMax    = 11'd2047;
   localparam logic [10:0] SyncTimeoutRst = 11'd1300;
   localparam logic [10:0] DataTimeoutRst = 11'd1500;

   localparam logic [1:0] KindStart = 2'd0;
   localparam logic [1:0] KindByte  = 2'd1;
   localparam logic [1:0] KindTick  = 2'd2;

   localparam logic CsrSyncTimeout = 1'b0;
   localparam logic CsrDataTimeout = 1'b1;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SYNC_TOUT = 3'd1,
      ST_ZERO_LEN  = 3'd2,
      ST_SHORT     = 3'd3,
      ST_CSUM_STD  = 3'd4,
      ST_CSUM_OTH  = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_SYNC = 3'b010,
      PH_BODY = 3'b100
   } phase_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } cmd_type;

   typedef struct packed {
      logic        is_word;
      logic [3:0]  word_index;
      logic [15:0] word_value;
      status_type  status;
      logic        device_type;
      logic [15:0] frame_length;
      logic        last;
   } result_type;

endpackage

// ===== rtl/sfp_front.sv =====
module sfp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_kind,
   input  logic [7:0]         req_rx_byte,
   output logic               cmd_valid,
   output sfp_pkg::cmd_type   cmd,
   input  logic               cmd_pop
);

   sfp_pkg::cmd_type mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       accept;
   logic       keep;
   logic       do_write;
   logic       do_read;
   sfp_pkg::cmd_type new_cmd;

   always_comb begin
      keep = 1'b1;
      new_cmd.data = req_rx_byte;
      unique case (req_kind)
         sfp_pkg::KindStart: new_cmd.op = sfp_pkg::OP_START;
         sfp_pkg::KindByte:  new_cmd.op = sfp_pkg::OP_BYTE;
         sfp_pkg::KindTick:  new_cmd.op = sfp_pkg::OP_TICK;
         default: begin
            new_cmd.op = sfp_pkg::OP_TICK;
            keep       = 1'b0;
         end
      endcase
   end

   assign req_full  = (count_ff == 3'd4);
   assign accept    = req_push && !req_full;
   assign do_write  = accept && keep;
   assign cmd_valid = (count_ff != 3'd0);
   assign do_read   = cmd_pop && cmd_valid;
   assign cmd       = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = do_write ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
   assign rd_ptr_in = do_read ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
   assign count_in  = count_ff + {2'b00, do_write} - {2'b00, do_read};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== rtl/sfp_rsp_queue.sv =====
module sfp_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sfp_pkg::result_type  push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output sfp_pkg::result_type  head
);

   sfp_pkg::result_type mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       do_write;
   logic       do_read;

   assign full     = (count_ff == 3'd4);
   assign empty    = (count_ff == 3'd0);
   assign do_write = push && !full;
   assign do_read  = pop && !empty;
   assign head     = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = do_write ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
   assign rd_ptr_in = do_read ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
   assign count_in  = count_ff + {2'b00, do_write} - {2'b00, do_read};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/sfp_back.sv =====
module sfp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic                 csr_index,
   input  logic [10:0]          csr_data,
   input  logic                 cmd_valid,
   input  sfp_pkg::cmd_type     cmd,
   output logic                 cmd_pop,
   output logic                 rsp_push,
   output sfp_pkg::result_type  rsp_data,
   input  logic                 rsp_full
);

   sfp_pkg::phase_type  phase_ff, phase_in;
   logic [7:0]          prev_ff, prev_in;
   logic [5:0]          count_ff, count_in;
   logic [15:0]         length_ff, length_in;
   logic [15:0]         sum_ff, sum_in;
   logic [10:0]         elapsed_ff, elapsed_in;
   logic [15:0]         final_ff, final_in;
   logic [10:0]         sync_tout_ff;
   logic [10:0]         data_tout_ff;
   logic                pend_valid_ff, pend_valid_in;
   sfp_pkg::result_type pend_ff, pend_in;

   sfp_pkg::result_type res0, res1;
   logic [1:0]          n_res;
   logic                consume;
   logic [10:0]         elapsed_inc;
   logic [5:0]          count_nx;
   logic [15:0]         sum_nx;
   logic [15:0]         word;
   logic [15:0]         length_nx;
   logic [4:0]          half;
   logic                done;
   logic [16:0]         need_nx;

   function automatic sfp_pkg::result_type judge(input logic [15:0] len,
                                                 input logic [5:0]  cnt,
                                                 input logic [15:0] sum,
                                                 input logic [15:0] fw);
      sfp_pkg::result_type r;
      logic [16:0] need;
      logic [15:0] body;
      r              = '0;
      need           = {1'b0, len} + 17'd4;
      body           = sum - {8'h00, fw[15:8]} - {8'h00, fw[7:0]};
      r.is_word      = 1'b0;
      r.frame_length = len;
      r.last         = 1'b1;
      r.status       = sfp_pkg::ST_OK;
      if (len == 16'd0) begin
         r.status = sfp_pkg::ST_ZERO_LEN;
      end else if ({11'd0, cnt} < need) begin
         r.status = sfp_pkg::ST_SHORT;
      end else begin
         r.device_type = (len != sfp_pkg::StdLength);
         if (body != fw) begin
            r.status = r.device_type ? sfp_pkg::ST_CSUM_OTH : sfp_pkg::ST_CSUM_STD;
         end
      end
      return r;
   endfunction

   assign consume     = cmd_valid && !pend_valid_ff && !rsp_full;
   assign cmd_pop     = consume;
   assign elapsed_inc = (elapsed_ff < sfp_pkg::ElapsedMax) ? elapsed_ff + 11'd1 : elapsed_ff;

   assign count_nx  = count_ff + 6'd1;
   assign sum_nx    = sum_ff + {8'h00, cmd.data};
   assign word      = {prev_ff, cmd.data};
   assign length_nx = (count_nx == 6'd4) ? word : length_ff;
   assign half      = count_nx[5:1] - 5'd1;
   assign need_nx   = {1'b0, length_nx} + 17'd4;
   assign done      = (count_nx >= 6'(sfp_pkg::BufferBytes)) ||
                      ((length_nx != 16'd0) && ({11'd0, count_nx} >= need_nx));

   always_comb begin
      phase_in   = phase_ff;
      prev_in    = prev_ff;
      count_in   = count_ff;
      length_in  = length_ff;
      sum_in     = sum_ff;
      elapsed_in = elapsed_ff;
      final_in   = final_ff;
      res0       = '0;
      res1       = '0;
      n_res      = 2'd0;
      if (consume) begin
         unique case (cmd.op)
            sfp_pkg::OP_START: begin
               phase_in   = sfp_pkg::PH_SYNC;
               prev_in    = 8'h00;
               count_in   = 6'd0;
               length_in  = 16'd0;
               sum_in     = 16'd0;
               elapsed_in = 11'd0;
               final_in   = 16'd0;
            end
            sfp_pkg::OP_TICK: begin
               if (phase_ff != sfp_pkg::PH_IDLE) begin
                  elapsed_in = elapsed_inc;
               end
               if (phase_ff == sfp_pkg::PH_SYNC && elapsed_inc >= sync_tout_ff) begin
                  phase_in           = sfp_pkg::PH_IDLE;
                  res0.status        = sfp_pkg::ST_SYNC_TOUT;
                  res0.frame_length  = length_ff;
                  res0.last          = 1'b1;
                  n_res              = 2'd1;
               end else if (phase_ff == sfp_pkg::PH_BODY && elapsed_inc >= data_tout_ff) begin
                  phase_in = sfp_pkg::PH_IDLE;
                  res0     = judge(length_ff, count_ff, sum_ff, final_ff);
                  n_res    = 2'd1;
               end
            end
            sfp_pkg::OP_BYTE: begin
               if (phase_ff == sfp_pkg::PH_SYNC) begin
                  prev_in = cmd.data;
                  if (prev_ff == sfp_pkg::SyncHigh && cmd.data == sfp_pkg::SyncLow) begin
                     phase_in          = sfp_pkg::PH_BODY;
                     count_in          = 6'd2;
                     elapsed_in        = 11'd0;
                     sum_in            = sfp_pkg::SyncSum;
                     final_in          = sfp_pkg::SyncWord;
                     res0.is_word      = 1'b1;
                     res0.word_value   = sfp_pkg::SyncWord;
                     res0.frame_length = length_ff;
                     res0.last         = 1'b1;
                     n_res             = 2'd1;
                  end
               end else if (phase_ff == sfp_pkg::PH_BODY) begin
                  prev_in   = cmd.data;
                  count_in  = count_nx;
                  sum_in    = sum_nx;
                  final_in  = word;
                  length_in = length_nx;
                  if (!count_nx[0]) begin
                     res0.is_word      = 1'b1;
                     res0.word_index   = half[3:0];
                     res0.word_value   = word;
                     res0.frame_length = length_nx;
                     res0.last         = !done;
                     n_res             = 2'd1;
                  end
                  if (done) begin
                     phase_in = sfp_pkg::PH_IDLE;
                     if (!count_nx[0]) begin
                        res1  = judge(length_nx, count_nx, sum_nx, word);
                        n_res = 2'd2;
                     end else begin
                        res0  = judge(length_nx, count_nx, sum_nx, word);
                        n_res = 2'd1;
                     end
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_push      = 1'b0;
      rsp_data      = res0;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (pend_valid_ff) begin
         rsp_data = pend_ff;
         if (!rsp_full) begin
            rsp_push      = 1'b1;
            pend_valid_in = 1'b0;
         end
      end else if (consume && n_res != 2'd0) begin
         rsp_push = 1'b1;
         if (n_res == 2'd2) begin
            pend_valid_in = 1'b1;
            pend_in       = res1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= sfp_pkg::PH_IDLE;
         prev_ff       <= 8'h00;
         count_ff      <= 6'd0;
         length_ff     <= 16'd0;
         sum_ff        <= 16'd0;
         elapsed_ff    <= 11'd0;
         final_ff      <= 16'd0;
         sync_tout_ff  <= sfp_pkg::SyncTimeoutRst;
         data_tout_ff  <= sfp_pkg::DataTimeoutRst;
         pend_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         prev_ff       <= prev_in;
         count_ff      <= count_in;
         length_ff     <= length_in;
         sum_ff        <= sum_in;
         elapsed_ff    <= elapsed_in;
         final_ff      <= final_in;
         pend_valid_ff <= pend_valid_in;
         if (csr_valid && csr_index == sfp_pkg::CsrSyncTimeout) begin
            sync_tout_ff <= csr_data;
         end
         if (csr_valid && csr_index == sfp_pkg::CsrDataTimeout) begin
            data_tout_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

endmodule

// ===== rtl/sensor_frame_parser.sv =====
// Sensor frame parser: finds the 0x42 0x4D sync pair, collects a length-framed
// frame of up to 32 bytes with sync, reports each 16-bit word, a final status.
// Request queue: push with kind (0 start, 1 byte, 2 millisecond tick) and
//   rx_byte; a transfer happens when push is high and full is low. Kind 3 is
//   dropped. A four-entry command queue sits in front of the parser.
// Response queue: the oldest result is shown while empty is low and leaves on
//   a transfer with pop high. A four-entry result queue holds finished results.
// Control register channel: index 0 sync timeout, index 1 data timeout, both
//   in milliseconds; ready is always high. Write only while the block is idle.
// Path: a request is registered in the command queue and its result in the
//   result queue before the result reaches the response ports.
// Throughput: one request per cycle unless a queue is full; a byte that closes
//   a frame on a word boundary gives two results; the second holds the parser.
// Reset clears both queues, returns the parser to idle and loads the timeouts
//   with 1300 and 1500. When pop stays low the result queue fills, the parser
//   halts, the command queue fills and full rises; nothing is lost.
module sensor_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_is_word,
   output logic [3:0]  rsp_word_index,
   output logic [15:0] rsp_word_value,
   output logic [2:0]  rsp_status,
   output logic        rsp_device_type,
   output logic [15:0] rsp_frame_length,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [10:0] csr_data
);

   logic                cmd_valid;
   logic                cmd_pop;
   sfp_pkg::cmd_type    cmd;
   logic                q_push;
   logic                q_full;
   sfp_pkg::result_type q_data;
   sfp_pkg::result_type head;

   assign csr_ready = 1'b1;

   sfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_kind    (req_kind),
      .req_rx_byte (req_rx_byte),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   sfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_push  (q_push),
      .rsp_data  (q_data),
      .rsp_full  (q_full)
   );

   sfp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (head)
   );

   assign rsp_is_word      = head.is_word;
   assign rsp_word_index   = head.word_index;
   assign rsp_word_value   = head.word_value;
   assign rsp_status       = head.status;
   assign rsp_device_type  = head.device_type;
   assign rsp_frame_length = head.frame_length;
   assign rsp_last         = head.last;

endmodule

// ===== test/tb_sensor_frame_parser.sv =====
`timescale 1ns / 1ps

module tb_sensor_frame_parser;
   import sfp_pkg::*;

   localparam logic [1:0] KindUnused = 2'd3;
   localparam int CycleLimit = 400000;
   localparam int RandomPerPhase = 190;
   localparam int DrainCycles = 16;

   typedef struct {
      logic [1:0] kind;
      logic [7:0] rx;
   } rx_item_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_kind = KindTick;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_is_word;
   logic [3:0]  rsp_word_index;
   logic [15:0] rsp_word_value;
   logic [2:0]  rsp_status;
   logic        rsp_device_type;
   logic [15:0] rsp_frame_length;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CsrSyncTimeout;
   logic [10:0] csr_data = 11'd0;

   sensor_frame_parser dut (.*);

   rx_item_t   req_items [$];
   result_type frame_results_due [$];
   result_type due;
   int         items_queued = 0;
   int         results_seen = 0;
   int         mismatches = 0;
   int         cycles = 0;
   int         hold_left = 0;
   logic       long_hold_done = 1'b0;
   logic       quiet;

   // parser image
   phase_type   ph = PH_IDLE;
   logic [7:0]  prev_byte = 8'h00;
   logic [5:0]  byte_cnt = 6'd0;
   logic [15:0] frame_len = 16'd0;
   logic [15:0] byte_sum = 16'd0;
   logic [10:0] elapsed = 11'd0;
   logic [15:0] last_word = 16'd0;
   logic [10:0] sync_limit = SyncTimeoutRst;
   logic [10:0] data_limit = DataTimeoutRst;

   assign quiet = cycles >= 1000 && cycles < 1600;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic result_type frame_result(logic w, logic [3:0] idx, logic [15:0] val,
                                               status_type st, logic dt, logic fin);
      result_type r;
      r.is_word      = w;
      r.word_index   = idx;
      r.word_value   = val;
      r.status       = st;
      r.device_type  = dt;
      r.frame_length = frame_len;
      r.last         = fin;
      return r;
   endfunction

   task automatic judge_frame();
      logic [16:0] need;
      logic [15:0] body;
      status_type  st;
      logic        dt;
      need = {1'b0, frame_len} + 17'd4;
      dt   = 1'b0;
      if (frame_len == 16'd0) begin
         st = ST_ZERO_LEN;
      end else if ({11'd0, byte_cnt} < need) begin
         st = ST_SHORT;
      end else begin
         body = byte_sum - {8'd0, last_word[15:8]} - {8'd0, last_word[7:0]};
         dt   = frame_len != StdLength;
         st   = (body == last_word) ? ST_OK : (dt ? ST_CSUM_OTH : ST_CSUM_STD);
      end
      frame_results_due.push_back(frame_result(1'b0, 4'd0, 16'd0, st, dt, 1'b1));
      ph = PH_IDLE;
   endtask

   task automatic parse_step(logic [1:0] k, logic [7:0] b);
      logic [15:0] word;
      logic        done;
      if (k == KindStart) begin
         ph        = PH_SYNC;
         prev_byte = 8'h00;
         byte_cnt  = 6'd0;
         frame_len = 16'd0;
         byte_sum  = 16'd0;
         elapsed   = 11'd0;
         last_word = 16'd0;
      end else if (k != KindUnused && ph != PH_IDLE) begin
         if (k == KindTick) begin
            if (elapsed != ElapsedMax)
               elapsed = elapsed + 11'd1;
            if (ph == PH_SYNC && elapsed >= sync_limit) begin
               ph = PH_IDLE;
               frame_results_due.push_back(
                  frame_result(1'b0, 4'd0, 16'd0, ST_SYNC_TOUT, 1'b0, 1'b1));
            end else if (ph == PH_BODY && elapsed >= data_limit) begin
               judge_frame();
            end
         end else if (ph == PH_SYNC) begin
            if (prev_byte == SyncHigh && b == SyncLow) begin
               ph        = PH_BODY;
               byte_cnt  = 6'd2;
               elapsed   = 11'd0;
               byte_sum  = SyncSum;
               last_word = SyncWord;
               frame_results_due.push_back(
                  frame_result(1'b1, 4'd0, SyncWord, ST_OK, 1'b0, 1'b1));
            end
            prev_byte = b;
         end else begin
            word      = {prev_byte, b};
            byte_cnt  = byte_cnt + 6'd1;
            byte_sum  = byte_sum + {8'd0, b};
            last_word = word;
            prev_byte = b;
            if (byte_cnt == 6'd4)
               frame_len = word;
            done = byte_cnt >= BufferBytes ||
                   (frame_len != 16'd0 && {11'd0, byte_cnt} >= {1'b0, frame_len} + 17'd4);
            if (!byte_cnt[0])
               frame_results_due.push_back(
                  frame_result(1'b1, 4'(byte_cnt[5:1] - 5'd1), word, ST_OK, 1'b0, !done));
            if (done)
               judge_frame();
         end
      end
   endtask

   task automatic add_item(logic [1:0] k, logic [7:0] b);
      rx_item_t it;
      it.kind = k;
      it.rx   = b;
      req_items.push_back(it);
      items_queued++;
   endtask

   task automatic queue_frame_run();
      logic [7:0]  fb [32];
      logic [15:0] flen;
      logic [15:0] csum;
      int          r, n, send, i;
      r = $urandom_range(99);
      if (r < 8) begin
         repeat ($urandom_range(1, 6)) begin
            r = $urandom_range(9);
            add_item(r < 6 ? KindByte : r < 8 ? KindTick : r < 9 ? KindUnused : KindStart,
                     8'($urandom));
         end
      end else if (r < 16 && sync_limit <= 11'd64) begin
         add_item(KindStart, 8'($urandom));
         repeat ($urandom_range(0, 3)) add_item(KindByte, 8'($urandom));
         repeat (int'(sync_limit) + $urandom_range(0, 1)) add_item(KindTick, 8'($urandom));
      end else begin
         r = $urandom_range(99);
         if (r < 35)
            flen = StdLength;
         else if (r < 60)
            flen = 16'($urandom_range(1, 27));
         else if (r < 67)
            flen = 16'd0;
         else if (r < 77)
            flen = 16'($urandom_range(29, 40));
         else if (r < 84)
            flen = 16'hFFFF - 16'($urandom_range(0, 3));
         else
            flen = 16'($urandom);
         n = (flen == 16'd0 || flen > StdLength) ? BufferBytes : int'(flen) + 4;
         fb[0] = SyncHigh;
         fb[1] = ($urandom_range(19) == 0) ? 8'($urandom) : SyncLow;
         fb[2] = flen[15:8];
         fb[3] = flen[7:0];
         for (i = 4; i < n; i++)
            fb[i] = 8'($urandom);
         if ($urandom_range(9) < 7) begin
            csum = 16'd0;
            for (i = 0; i < n - 2; i++)
               csum = csum + {8'd0, fb[i]};
            fb[n-2] = csum[15:8];
            fb[n-1] = csum[7:0];
         end
         send = ($urandom_range(9) == 0) ? $urandom_range(2, n - 1) : n;
         if ($urandom_range(19) != 0)
            add_item(KindStart, 8'($urandom));
         repeat ($urandom_range(0, 2)) add_item(KindByte, 8'($urandom));
         for (i = 0; i < send; i++) begin
            if ($urandom_range(49) == 0)
               add_item(KindTick, 8'($urandom));
            add_item(KindByte, fb[i]);
         end
         if (send < n && data_limit <= 11'd64)
            repeat (int'(data_limit) + 1) add_item(KindTick, 8'($urandom));
      end
   endtask

   task automatic csr_write(logic idx, logic [10:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CsrSyncTimeout)
         sync_limit = val;
      else
         data_limit = val;
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      do @(negedge clock);
      while (req_items.size() != 0 || req_push || frame_results_due.size() != 0);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic check_field(string name, logic [15:0] exp, logic [15:0] act);
      if (exp !== act) begin
         $error("%s: expected %0d, got %0d", name, exp, act);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("tb_sensor_frame_parser: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            parse_step(req_kind, req_rx_byte);
            void'(req_items.pop_front());
         end
         if (!(req_push && req_full)) begin
            if (req_items.size() != 0 && (quiet || $urandom_range(99) >= 6)) begin
               req_push    <= 1'b1;
               req_kind    <= req_items[0].kind;
               req_rx_byte <= req_items[0].rx;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (frame_results_due.size() == 0) begin
               $error("result transfer with nothing due: is_word %0d status %0d",
                      rsp_is_word, rsp_status);
               mismatches++;
            end else begin
               due = frame_results_due.pop_front();
               check_field("is_word", due.is_word, rsp_is_word);
               check_field("word_index", due.word_index, rsp_word_index);
               check_field("word_value", due.word_value, rsp_word_value);
               check_field("status", due.status, rsp_status);
               check_field("device_type", due.device_type, rsp_device_type);
               check_field("frame_length", due.frame_length, rsp_frame_length);
               check_field("last", due.last, rsp_last);
            end
         end
         // hold off the receiver once so both queues fill
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_pop   <= 1'b0;
         end else if (results_seen == 60 && !long_hold_done) begin
            hold_left      <= 400;
            long_hold_done <= 1'b1;
            rsp_pop        <= 1'b0;
         end else begin
            rsp_pop <= quiet || $urandom_range(99) >= 6;
         end
      end
   end

   initial begin
      logic [10:0] sync_set [7];
      logic [10:0] data_set [7];
      sync_set = '{SyncTimeoutRst, 11'd2047, 11'd0, 11'd1, 11'd2047, 11'd0, 11'd1};
      data_set = '{DataTimeoutRst, 11'd2047, 11'd0, 11'd1, 11'd1, 11'd0, 11'd2047};
      sync_set[5] = 11'($urandom_range(4, 60));
      data_set[5] = 11'($urandom_range(4, 60));
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 7; p++) begin
         if (p != 0) begin
            csr_write(CsrSyncTimeout, sync_set[p]);
            csr_write(CsrDataTimeout, data_set[p]);
         end
         @(negedge clock);
         if (p == 0) begin
            add_item(KindTick, 8'h00);
            add_item(KindByte, 8'hFF);
            add_item(KindUnused, 8'h5A);
            add_item(KindStart, 8'h00);
            add_item(KindByte, SyncHigh);
            add_item(KindStart, 8'hFF);
            add_item(KindByte, SyncHigh);
            add_item(KindByte, SyncLow);
            add_item(KindByte, 8'h00);
            add_item(KindByte, 8'h02);
            add_item(KindUnused, 8'hA5);
            add_item(KindByte, 8'h00);
            add_item(KindByte, 8'h91);
            add_item(KindStart, 8'h00);
            add_item(KindByte, SyncHigh);
            add_item(KindByte, SyncLow);
            add_item(KindByte, 8'h00);
            add_item(KindByte, 8'h01);
            add_item(KindByte, 8'hFF);
            add_item(KindStart, 8'h00);
            add_item(KindByte, SyncHigh);
            add_item(KindByte, SyncLow);
            add_item(KindByte, 8'h00);
            add_item(KindByte, 8'h02);
            add_item(KindByte, 8'hFF);
            add_item(KindByte, 8'hFF);
         end else if (p == 1) begin
            add_item(KindStart, 8'h00);
            repeat (20) add_item(KindTick, 8'($urandom));
            add_item(KindStart, 8'h00);
            add_item(KindByte, SyncHigh);
            add_item(KindByte, SyncLow);
            add_item(KindByte, 8'h00);
            add_item(KindByte, 8'h00);
            repeat (20) add_item(KindTick, 8'($urandom));
         end
         items_queued = 0;
         while (items_queued < RandomPerPhase)
            queue_frame_run();
         drain();
      end
      if (mismatches == 0)
         $display("tb_sensor_frame_parser: done, clean");
      else
         $display("tb_sensor_frame_parser: done, errors");
      $finish;
   end

endmodule
